### rtl/trapezoidal_motion_profile_macros.svh
// assertion macros for the motion profile block
`ifndef TRAPEZOIDAL_MOTION_PROFILE_MACROS_SVH
`define TRAPEZOIDAL_MOTION_PROFILE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TMP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TMP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define TMP_ASSERT(label, clk, rst_n, prop, msg)
`define TMP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

### rtl/tmp_pkg.sv
package tmp_pkg;

  localparam int unsigned W = 64;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] THRESH = 64'sd42949673;

  localparam logic [62:0] MAX_SPEED_RST = 63'd42949672960;
  localparam logic [62:0] MAX_ACCEL_RST = 63'd214748364800;
  localparam logic [32:0] PERIOD_RST = 33'd429497;

  localparam logic [1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [1:0] REG_MAX_ACCEL = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;

  // datapath micro-operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,      // latch word, apply abort
    OP_TA_DIV,    // ta = vmax / amax
    OP_TA_SQ,     // tmp = ta*ta
    OP_RAMP,      // ramp = amax*tmp / 2
    OP_START,     // start test and setup
    OP_CT_DIV,    // cruise_time division
    OP_SHAPE,     // choose trapezoid or roof
    OP_ROOF_DIV,  // tmp = dmul(req-meas) / amax
    OP_ROOF_SQRT, // total = 2*sqrt(tmp)
    OP_TICK,      // advance time, pick phase
    OP_SPD_MUL,   // speed update
    OP_POS_MUL,   // position update
    OP_FINISH     // clamps, end test, output
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_TA, S_TA_SQ, S_RAMP, S_START, S_CT, S_SHAPE,
    S_ROOF_DIV, S_ROOF_SQRT, S_TICK, S_SPD, S_POS, S_FINISH, S_OUT
  } state_e;

  typedef struct packed {
    op_e  op;
    logic go;   // start of a multicycle unit
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic need_start; // elapsed time zero
  } stat_t;

  function automatic logic signed [W-1:0] sadd(logic signed [W-1:0] a,
                                               logic signed [W-1:0] b);
    logic signed [W-1:0] s;
    s = a + b;
    if (a[W-1] == b[W-1] && s[W-1] != a[W-1]) s = a[W-1] ? SMIN : SMAX;
    return s;
  endfunction

  function automatic logic signed [W-1:0] sneg(logic signed [W-1:0] a);
    return (a == SMIN) ? SMAX : -a;
  endfunction

  function automatic logic signed [W-1:0] ssub(logic signed [W-1:0] a,
                                               logic signed [W-1:0] b);
    logic signed [W-1:0] s;
    s = a - b;
    if (a[W-1] != b[W-1] && s[W-1] != a[W-1]) s = a[W-1] ? SMIN : SMAX;
    return s;
  endfunction

  function automatic logic [W-1:0] mag(logic signed [W-1:0] a);
    return a[W-1] ? (~a + 64'd1) : a;
  endfunction

  function automatic logic signed [W-1:0] from_mag(logic [W-1:0] m, logic neg,
                                                   logic over);
    logic signed [W-1:0] r;
    if (neg) r = (over || m[W-1]) ? SMIN : -m;
    else r = (over || m[W-1]) ? SMAX : m;
    return r;
  endfunction

endpackage

### rtl/tmp_if.sv
interface tmp_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] requested_position;
  logic signed [63:0] measured_position;
  logic               abort;
  logic               abort_clear_position;
  modport source (output valid, requested_position, measured_position, abort,
                  abort_clear_position, input ready);
  modport sink (input valid, requested_position, measured_position, abort,
                abort_clear_position, output ready);
endinterface

interface tmp_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] profile_position;
  logic signed [63:0] profile_speed;
  logic signed [63:0] profile_accel;
  logic signed [63:0] start_position;
  logic               moving;
  logic               finished;
  modport source (output valid, profile_position, profile_speed, profile_accel,
                  start_position, moving, finished, input ready);
  modport sink (input valid, profile_position, profile_speed, profile_accel,
                start_position, moving, finished, output ready);
endinterface

### rtl/tmp_mul.sv
// unsigned 64x64 q32.32 product, one 32x32 partial product per cycle
module tmp_mul
  import tmp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  a_i,
  input  logic [W-1:0]  b_i,
  output logic          busy_o,
  output logic [W-1:0]  res_o,   // bits 95:32 of the product
  output logic          over_o   // bits 127:96 nonzero
);
  logic [W-1:0]   a_q, b_q;
  logic [127:0]   acc_q, acc_d;
  logic [2:0]     cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic [31:0]    pa, pb;
  logic [63:0]    pp;
  logic [127:0]   sh;

  always_comb begin
    pa = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    pb = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    sh = {64'd0, pp} << (7'd32 * {5'd0, cnt_q[1]} + 7'd32 * {5'd0, cnt_q[0]});
    acc_d = acc_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + sh;
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd3) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
  end

  assign busy_o = busy_q;
  assign res_o = acc_q[95:32];
  assign over_o = |acc_q[127:96];
endmodule

### rtl/tmp_div.sv
// restoring divider (n << 32) / d, one quotient bit per cycle, also floor sqrt
module tmp_div
  import tmp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          sqrt_i,
  input  logic [W-1:0]  n_i,
  input  logic [W-1:0]  d_i,
  output logic          busy_o,
  output logic [W-1:0]  q_o,
  output logic          over_o
);
  logic [127:0] num_q, num_d;
  logic [64:0]  rem_q, rem_d;
  logic [63:0]  d_q;
  logic [63:0]  qlo_q, qlo_d;
  logic         qhi_q, qhi_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d, sq_q;
  logic [65:0]  srem, strial;
  logic [64:0]  rsh;

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    qlo_d = qlo_q;
    qhi_d = qhi_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    rsh = '0;
    srem = '0;
    strial = '0;
    if (start_i) begin
      // both the quotient and the root work on n << 32
      num_d = {32'd0, n_i, 32'd0};
      rem_d = '0;
      qlo_d = '0;
      qhi_d = 1'b0;
      cnt_d = sqrt_i ? 7'd64 : 7'd127;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!sq_q) begin
        rsh = {rem_q[63:0], num_q[127]};
        num_d = {num_q[126:0], 1'b0};
        qhi_d = qhi_q | qlo_q[63];
        if (rsh >= {1'b0, d_q}) begin
          rem_d = rsh - {1'b0, d_q};
          qlo_d = {qlo_q[62:0], 1'b1};
        end else begin
          rem_d = rsh;
          qlo_d = {qlo_q[62:0], 1'b0};
        end
      end else begin
        // digit-by-digit root over 128-bit radicand, two bits per step
        srem = {rem_q, num_q[127]} ;
        srem = {srem[64:0], num_q[126]};
        strial = {qlo_q[63:0], 2'b01};
        num_d = {num_q[125:0], 2'b00};
        if (srem >= strial) begin
          rem_d = 65'(srem - strial);
          qlo_d = {qlo_q[62:0], 1'b1};
        end else begin
          rem_d = srem[64:0];
          qlo_d = {qlo_q[62:0], 1'b0};
        end
      end
      if (cnt_q == 7'd0 || (sq_q && cnt_q == 7'd1)) busy_d = 1'b0;
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    qlo_q <= qlo_d;
    qhi_q <= qhi_d;
    if (start_i) begin
      d_q <= d_i;
      sq_q <= sqrt_i;
    end
  end

  assign busy_o = busy_q;
  assign q_o = qlo_q;
  assign over_o = qhi_q;
endmodule

### rtl/tmp_datapath.sv
module tmp_datapath
  import tmp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic [62:0]        max_speed_i,
  input  logic [62:0]        max_accel_i,
  input  logic [32:0]        period_i,
  input  logic signed [W-1:0] req_i,
  input  logic signed [W-1:0] meas_i,
  input  logic               abort_i,
  input  logic               abort_clr_i,
  output logic signed [W-1:0] pos_o,
  output logic signed [W-1:0] spd_o,
  output logic signed [W-1:0] acc_o,
  output logic signed [W-1:0] org_o,
  output logic               moving_o,
  output logic               finished_o
);
  logic signed [W-1:0] req_q, meas_q, et_q, lreq_q, org_q, pos_q, spd_q, acc_q;
  logic signed [W-1:0] cd_q, ct_q, tot_q, ta_q, tmp_q, ramp_q;
  logic signed [W-1:0] et_d, lreq_d, org_d, pos_d, spd_d, acc_d;
  logic signed [W-1:0] cd_d, ct_d, tot_d, ta_d, tmp_d, ramp_d, req_d, meas_d;
  logic [1:0] dir_q, dir_d;   // 01 plus, 11 minus, 00 none
  logic tick_q, tick_d, tri_q, tri_d, mov_q, mov_d, fin_q, fin_d;
  logic strt_q, strt_d;       // a profile started on this word
  logic [1:0] ph_q, ph_d;     // 0 none, 1 accel, 2 cruise, 3 decel

  logic mstart, dstart, dsqrt, mbusy, mover, dbusy, dover;
  logic [W-1:0] ma, mb, mres, dn, dd, dq;
  logic msign_q, msign_d, dsign_q, dsign_d;
  logic signed [W-1:0] mval, two_ramp, bound, target, diff, cend, half, dd_s;

  tmp_mul u_mul (.clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb),
    .busy_o(mbusy), .res_o(mres), .over_o(mover));
  tmp_div u_div (.clk_i, .rst_ni, .start_i(dstart), .sqrt_i(dsqrt), .n_i(dn),
    .d_i(dd), .busy_o(dbusy), .q_o(dq), .over_o(dover));

  function automatic logic signed [W-1:0] dmul(logic [1:0] dr, logic signed [W-1:0] x);
    logic signed [W-1:0] r;
    r = '0;
    if (dr == 2'b01) r = x;
    else if (dr == 2'b11) r = sneg(x);
    return r;
  endfunction

  assign mval = from_mag(mres, msign_q, mover);
  assign two_ramp = sadd(ramp_q, ramp_q);
  assign bound = sadd(two_ramp, dmul(dir_q, cd_q));
  assign target = sadd(dmul(dir_q, two_ramp), cd_q);
  assign diff = ssub(req_q, meas_q);
  assign cend = sadd(ta_q, ct_q);
  assign half = tot_q / 2;
  assign dd_s = W'(signed'({1'b0, max_accel_i}));

  // divider operand selection per op; the zero divisor path is handled here
  logic signed [W-1:0] dnum_s, dden_s, dz_s;
  logic dzero_q, dzero_d;
  logic signed [W-1:0] dres;
  always_comb begin
    dnum_s = '0;
    dden_s = 64'sd1;
    unique case (cmd_i.op)
      OP_TA_DIV:   begin dnum_s = {1'b0, max_speed_i}; dden_s = dd_s; end
      OP_CT_DIV:   begin
        dnum_s = (dir_q == 2'b01) ? cd_q : sneg(cd_q);
        dden_s = {1'b0, max_speed_i};
      end
      OP_ROOF_DIV: begin dnum_s = dmul(dir_q, diff); dden_s = dd_s; end
      OP_ROOF_SQRT: begin dnum_s = tmp_q; dden_s = 64'sd1; end
      default: ;
    endcase
    dz_s = dnum_s;
  end
  assign dstart = cmd_i.go && (cmd_i.op == OP_TA_DIV || cmd_i.op == OP_CT_DIV ||
                  cmd_i.op == OP_ROOF_DIV || cmd_i.op == OP_ROOF_SQRT);
  assign dsqrt = cmd_i.op == OP_ROOF_SQRT;
  assign dn = (dsqrt && dnum_s[W-1]) ? '0 : mag(dnum_s);
  assign dd = mag(dden_s);
  assign dsign_d = dstart ? (dnum_s[W-1] != dden_s[W-1]) && !dsqrt : dsign_q;
  assign dzero_d = dstart ? (dden_s == '0) : dzero_q;
  logic signed [W-1:0] dnum_q;
  assign dres = dzero_q ? (dnum_q == '0 ? '0 : (dnum_q[W-1] ? SMIN : SMAX))
                        : from_mag(dq, dsign_q, dover);

  // multiplier operand selection
  logic signed [W-1:0] ma_s, mb_s;
  always_comb begin
    ma_s = '0;
    mb_s = '0;
    unique case (cmd_i.op)
      OP_TA_SQ:   begin ma_s = ta_q; mb_s = ta_q; end
      OP_RAMP:    begin ma_s = {1'b0, max_accel_i}; mb_s = tmp_q; end
      OP_SPD_MUL: begin ma_s = acc_q; mb_s = {31'd0, period_i}; end
      OP_POS_MUL: begin ma_s = spd_q; mb_s = {31'd0, period_i}; end
      default: ;
    endcase
  end
  assign mstart = cmd_i.go && (cmd_i.op == OP_TA_SQ || cmd_i.op == OP_RAMP ||
                  cmd_i.op == OP_SPD_MUL || cmd_i.op == OP_POS_MUL);
  assign ma = mag(ma_s);
  assign mb = mag(mb_s);
  assign msign_d = mstart ? (ma_s[W-1] != mb_s[W-1]) : msign_q;

  always_comb begin
    req_d = req_q; meas_d = meas_q; et_d = et_q; lreq_d = lreq_q; org_d = org_q;
    pos_d = pos_q; spd_d = spd_q; acc_d = acc_q; cd_d = cd_q; ct_d = ct_q;
    tot_d = tot_q; ta_d = ta_q; tmp_d = tmp_q; ramp_d = ramp_q; dir_d = dir_q;
    tick_d = tick_q; tri_d = tri_q; mov_d = mov_q; fin_d = fin_q; ph_d = ph_q;
    strt_d = strt_q;
    if (!cmd_i.go) begin
      unique case (cmd_i.op)
        OP_LOAD: begin
          req_d = req_i;
          meas_d = meas_i;
          mov_d = 1'b0;
          fin_d = 1'b0;
          if (abort_i) begin
            et_d = '0; tick_d = 1'b0; acc_d = '0; spd_d = '0;
            if (abort_clr_i) pos_d = '0;
          end
        end
        OP_TA_DIV:   ta_d = dres;
        OP_TA_SQ:    tmp_d = mval;
        OP_RAMP:     ramp_d = (mval >>> 1) + ((mval[W-1] && mval[0]) ? 64'sd1 : 64'sd0);
        OP_START: begin
          strt_d = 1'b0;
          if (et_q == '0) begin
            if (ssub(req_q, lreq_q) > THRESH || ssub(req_q, lreq_q) < -THRESH) begin
              tick_d = 1'b1; lreq_d = req_q; org_d = meas_q; pos_d = '0;
              strt_d = 1'b1;
              if (req_q > meas_q) begin
                cd_d = ssub(diff, two_ramp); dir_d = 2'b01;
              end else begin
                cd_d = sadd(diff, two_ramp); dir_d = 2'b11;
              end
            end
          end
        end
        // cruise time only changes when a new profile starts
        OP_CT_DIV:   if (strt_q) ct_d = dres;
        OP_SHAPE: begin
          if (ct_q > 0) begin
            tri_d = 1'b0;
            tot_d = sadd(sadd(ta_q, ta_q), ct_q);
          end else tri_d = 1'b1;
        end
        OP_ROOF_DIV: tmp_d = dres;
        OP_ROOF_SQRT: if (tri_q) tot_d = sadd(dres, dres);
        OP_TICK: begin
          if (tick_q) begin
            et_d = sadd(et_q, {31'd0, period_i});
            mov_d = 1'b1;
          end
          ph_d = 2'd0;
          if (!tri_q) begin
            if (et_d > 0 && et_d <= ta_q) begin
              ph_d = 2'd1; acc_d = dmul(dir_q, {1'b0, max_accel_i});
            end else if (et_d > ta_q && et_d <= cend) begin
              ph_d = 2'd2; acc_d = '0; spd_d = dmul(dir_q, {1'b0, max_speed_i});
            end else if (et_d > cend && et_d <= tot_q) begin
              ph_d = 2'd3; acc_d = sneg(dmul(dir_q, {1'b0, max_accel_i}));
            end
          end else begin
            if (et_d > 0 && et_d <= half) begin
              ph_d = 2'd1; acc_d = dmul(dir_q, {1'b0, max_accel_i});
            end else if (et_d > half && et_d <= tot_q) begin
              ph_d = 2'd3; acc_d = sneg(dmul(dir_q, {1'b0, max_accel_i}));
            end
          end
        end
        OP_SPD_MUL: begin
          if (ph_q == 2'd1 || ph_q == 2'd3) spd_d = sadd(spd_q, mval);
          if (!tri_q && ph_q == 2'd3 && dmul(dir_q, spd_d) < 0) spd_d = '0;
        end
        OP_POS_MUL: if (ph_q != 2'd0) pos_d = sadd(pos_q, mval);
        OP_FINISH: begin
          if (ph_q == 2'd3 && dmul(dir_q, pos_q) >= bound) begin
            pos_d = target;
            if (tri_q) begin spd_d = '0; acc_d = '0; end
          end
          if (et_q > tot_q) begin
            if (dmul(dir_q, pos_q) < bound) pos_d = target;
            et_d = '0; tick_d = 1'b0; acc_d = '0; spd_d = '0;
            fin_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      et_q <= '0; lreq_q <= '0; org_q <= '0; pos_q <= '0; spd_q <= '0;
      acc_q <= '0; cd_q <= '0; ct_q <= '0; tot_q <= '0; dir_q <= '0;
      tick_q <= 1'b0; tri_q <= 1'b0; mov_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      et_q <= et_d; lreq_q <= lreq_d; org_q <= org_d; pos_q <= pos_d;
      spd_q <= spd_d; acc_q <= acc_d; cd_q <= cd_d; ct_q <= ct_d;
      tot_q <= tot_d; dir_q <= dir_d; tick_q <= tick_d; tri_q <= tri_d;
      mov_q <= mov_d; fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; meas_q <= meas_d; ta_q <= ta_d; tmp_q <= tmp_d;
    ramp_q <= ramp_d; ph_q <= ph_d; msign_q <= msign_d; dsign_q <= dsign_d;
    dzero_q <= dzero_d; strt_q <= strt_d;
    if (dstart) dnum_q <= dz_s;
  end

  assign stat_o.busy = mbusy | dbusy;
  assign stat_o.need_start = (et_q == '0);
  assign pos_o = pos_q;
  assign spd_o = spd_q;
  assign acc_o = acc_q;
  assign org_o = org_q;
  assign moving_o = mov_q;
  assign finished_o = fin_q;
endmodule

### rtl/tmp_ctrl.sv
module tmp_ctrl
  import tmp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  input  stat_t  stat_i,
  output cmd_t   cmd_o,
  output state_e state_o
);
  state_e state_q, state_d;
  logic   go_q, go_d;   // first cycle in a unit state launches the unit
  logic   rslt_q, rslt_d;
  logic   start_ok;

  assign start_ok = stat_i.need_start;

  always_comb begin
    state_d = state_q;
    go_d = 1'b0;
    rslt_d = rslt_q;
    if (rslt_q && out_ready_i) rslt_d = 1'b0;
    unique case (state_q)
      S_IDLE:   if (in_valid_i && !rslt_q) state_d = S_LOAD;
      S_LOAD:   begin state_d = S_TA; go_d = 1'b1; end
      S_TA:     if (!go_q && !stat_i.busy) begin state_d = S_TA_SQ; go_d = 1'b1; end
      S_TA_SQ:  if (!go_q && !stat_i.busy) begin state_d = S_RAMP; go_d = 1'b1; end
      S_RAMP:   if (!go_q && !stat_i.busy) state_d = S_START;
      S_START:  if (start_ok) begin state_d = S_CT; go_d = 1'b1; end
                else state_d = S_TICK;
      S_CT:     if (!go_q && !stat_i.busy) state_d = S_SHAPE;
      S_SHAPE:  begin state_d = S_ROOF_DIV; go_d = 1'b1; end
      S_ROOF_DIV:  if (!go_q && !stat_i.busy) begin
                     state_d = S_ROOF_SQRT; go_d = 1'b1;
                   end
      S_ROOF_SQRT: if (!go_q && !stat_i.busy) state_d = S_TICK;
      S_TICK:   begin state_d = S_SPD; go_d = 1'b1; end
      S_SPD:    if (!go_q && !stat_i.busy) begin state_d = S_POS; go_d = 1'b1; end
      S_POS:    if (!go_q && !stat_i.busy) state_d = S_FINISH;
      S_FINISH: state_d = S_OUT;
      S_OUT:    begin state_d = S_IDLE; rslt_d = 1'b1; end
      default:  state_d = S_IDLE;
    endcase
  end

  // the roof steps run on every word that takes the setup path and only set the total when the shape is a roof
  always_comb begin
    cmd_o.op = OP_NOP;
    cmd_o.go = go_q;
    unique case (state_q)
      // the word is latched at its accepting edge
      S_IDLE:      if (in_valid_i && !rslt_q) cmd_o.op = OP_LOAD;
      S_TA:        cmd_o.op = OP_TA_DIV;
      S_TA_SQ:     cmd_o.op = OP_TA_SQ;
      S_RAMP:      cmd_o.op = OP_RAMP;
      S_START:     cmd_o.op = OP_START;
      S_CT:        cmd_o.op = OP_CT_DIV;
      S_SHAPE:     cmd_o.op = OP_SHAPE;
      S_ROOF_DIV:  cmd_o.op = OP_ROOF_DIV;
      S_ROOF_SQRT: cmd_o.op = OP_ROOF_SQRT;
      S_TICK:      cmd_o.op = OP_TICK;
      S_SPD:       cmd_o.op = OP_SPD_MUL;
      S_POS:       cmd_o.op = OP_POS_MUL;
      S_FINISH:    cmd_o.op = OP_FINISH;
      default:     cmd_o.op = OP_NOP;
    endcase
    if (!(!go_q && !stat_i.busy) && state_q != S_LOAD && state_q != S_START &&
        state_q != S_SHAPE && state_q != S_TICK && state_q != S_FINISH)
      cmd_o.op = go_q ? cmd_o.op : OP_NOP;
    in_ready_o = (state_q == S_IDLE) && !rslt_q;
    out_valid_o = rslt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      go_q <= 1'b0;
      rslt_q <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q <= go_d;
      rslt_q <= rslt_d;
    end
  end

  assign state_o = state_q;
endmodule

### rtl/trapezoidal_motion_profile.sv
// work per word: three 128-step divisions, a 64-step root and four products
// while no profile runs, one division and four products while a profile
// runs; all of it goes through the shared bit-serial divider and multiplier.
// throughput: one word at a time; next word taken once the result is taken.
// reset: asynchronous active low; profile state zero, registers to defaults.
`include "trapezoidal_motion_profile_macros.svh"
module trapezoidal_motion_profile
  import tmp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tmp_in_if.sink      in_if,
  tmp_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [62:0] cfg_data_i
);
  logic [62:0] max_speed_q, max_accel_q;
  logic [32:0] period_q;
  cmd_t   cmd;
  stat_t  stat;
  state_e state;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= MAX_SPEED_RST;
      max_accel_q <= MAX_ACCEL_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAX_SPEED: max_speed_q <= cfg_data_i;
        REG_MAX_ACCEL: max_accel_q <= cfg_data_i;
        REG_PERIOD:    period_q <= cfg_data_i[32:0];
        default: ;
      endcase
    end
  end

  tmp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .stat_i(stat), .cmd_o(cmd), .state_o(state)
  );

  tmp_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .max_speed_i(max_speed_q), .max_accel_i(max_accel_q), .period_i(period_q),
    .req_i(in_if.requested_position), .meas_i(in_if.measured_position),
    .abort_i(in_if.abort), .abort_clr_i(in_if.abort_clear_position),
    .pos_o(out_if.profile_position), .spd_o(out_if.profile_speed),
    .acc_o(out_if.profile_accel), .org_o(out_if.start_position),
    .moving_o(out_if.moving), .finished_o(out_if.finished)
  );

  `TMP_ASSERT(a_no_take_busy, clk_i, rst_ni, !(in_if.ready && out_if.valid), "input taken while result pending")
  `TMP_ASSERT_NEXT(a_accept_load, clk_i, rst_ni, in_if.valid && in_if.ready, state == S_LOAD, "accepted word not loaded")
  `TMP_ASSERT(a_idle_units, clk_i, rst_ni, !(state == S_IDLE && stat.busy), "unit busy while idle")
endmodule

### tb/trapezoidal_motion_profile_tb.sv
module trapezoidal_motion_profile_tb;
  import tmp_pkg::*;

  typedef logic signed [63:0] q_t;

  typedef struct {
    q_t   req;
    q_t   meas;
    logic abort;
    logic clear_pos;
  } tick_t;

  typedef struct {
    q_t   pos;
    q_t   speed;
    q_t   accel;
    q_t   origin;
    logic moving;
    logic finished;
  } sample_t;

  class motion_scoreboard;
    q_t vmax, amax, period;
    q_t elapsed, last_req, origin, rel_pos, speed, accel;
    q_t cruise_dist, cruise_t, total_t;
    int dir;
    bit ticking, roof;
    sample_t pending_samples[$];
    int errors, ticks, checked, starts, finishes, aborts;

    function new();
      vmax = MAX_SPEED_RST;
      amax = MAX_ACCEL_RST;
      period = PERIOD_RST;
      elapsed = 0; last_req = 0; origin = 0; rel_pos = 0; speed = 0; accel = 0;
      cruise_dist = 0; cruise_t = 0; total_t = 0;
      dir = 0; ticking = 0; roof = 0;
      errors = 0; ticks = 0; checked = 0; starts = 0; finishes = 0; aborts = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [62:0] data);
      case (idx)
        REG_MAX_SPEED: vmax = {1'b0, data};
        REG_MAX_ACCEL: amax = {1'b0, data};
        REG_PERIOD:    period = {31'b0, data[32:0]};
        default: ;
      endcase
    endfunction

    function q_t add_sat(q_t a, q_t b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
      return s[63:0];
    endfunction

    function q_t sub_sat(q_t a, q_t b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
      return s[63:0];
    endfunction

    function q_t neg_sat(q_t a);
      return (a == SMIN) ? SMAX : -a;
    endfunction

    function logic [63:0] abs_u(q_t a);
      return a[63] ? (~a + 64'd1) : a;
    endfunction

    function q_t clip(logic [63:0] m, bit neg, bit over);
      if (neg) return (over || m[63]) ? SMIN : -m;
      return (over || m[63]) ? SMAX : m;
    endfunction

    function q_t fx_mul(q_t a, q_t b);
      logic [127:0] p;
      p = {64'b0, abs_u(a)} * {64'b0, abs_u(b)};
      return clip(p[95:32], a[63] ^ b[63], |p[127:96]);
    endfunction

    function q_t fx_div(q_t a, q_t b);
      logic [127:0] n, q;
      if (b == 0) return (a == 0) ? 0 : (a[63] ? SMIN : SMAX);
      n = {32'b0, abs_u(a), 32'b0};
      q = n / {64'b0, abs_u(b)};
      return clip(q[63:0], a[63] ^ b[63], |q[127:64]);
    endfunction

    function q_t fx_sqrt(q_t x);
      logic [63:0] lo, hi, m;
      logic [127:0] r;
      if (x <= 0) return 0;
      lo = 0;
      hi = 64'd1 << 48;
      r = {32'b0, x, 32'b0};
      while (hi - lo > 1) begin
        m = lo + (hi - lo) / 2;
        if ({64'b0, m} * {64'b0, m} <= r) lo = m;
        else hi = m;
      end
      return lo;
    endfunction

    function q_t signed_dir(q_t x);
      if (dir > 0) return x;
      if (dir < 0) return neg_sat(x);
      return 0;
    endfunction

    function void stop_motion(bit full);
      elapsed = 0;
      ticking = 0;
      accel = 0;
      speed = 0;
      if (full) rel_pos = 0;
    endfunction

    // one control tick of the profile
    function void advance_profile(tick_t w);
      q_t ta, ramp, two_ramp, bound, target, t, d, delta, s, cruise_end, half;
      sample_t r;
      bit moved, done;
      moved = 0;
      done = 0;
      ticks++;
      ta = fx_div(vmax, amax);
      ramp = fx_mul(amax, fx_mul(ta, ta)) / 2;
      two_ramp = add_sat(ramp, ramp);
      if (w.abort) begin
        stop_motion(w.clear_pos);
        aborts++;
      end
      if (elapsed == 0) begin
        d = sub_sat(w.req, last_req);
        if (d > THRESH || d < -THRESH) begin
          delta = sub_sat(w.req, w.meas);
          ticking = 1;
          last_req = w.req;
          origin = w.meas;
          rel_pos = 0;
          starts++;
          if (w.req > w.meas) begin
            cruise_dist = sub_sat(delta, two_ramp);
            cruise_t = fx_div(cruise_dist, vmax);
            dir = 1;
          end else begin
            cruise_dist = add_sat(delta, two_ramp);
            cruise_t = fx_div(neg_sat(cruise_dist), vmax);
            dir = -1;
          end
        end
        if (cruise_t > 0) begin
          roof = 0;
          total_t = add_sat(add_sat(ta, ta), cruise_t);
        end else begin
          roof = 1;
          s = fx_sqrt(fx_div(signed_dir(sub_sat(w.req, w.meas)), amax));
          total_t = add_sat(s, s);
        end
      end
      if (ticking) begin
        elapsed = add_sat(elapsed, period);
        moved = 1;
      end
      t = elapsed;
      bound = add_sat(two_ramp, signed_dir(cruise_dist));
      target = add_sat(signed_dir(two_ramp), cruise_dist);
      if (!roof) begin
        cruise_end = add_sat(ta, cruise_t);
        if (t > 0 && t <= ta) begin
          accel = signed_dir(amax);
          speed = add_sat(speed, fx_mul(accel, period));
          rel_pos = add_sat(rel_pos, fx_mul(speed, period));
        end else if (t > ta && t <= cruise_end) begin
          accel = 0;
          speed = signed_dir(vmax);
          rel_pos = add_sat(rel_pos, fx_mul(speed, period));
        end else if (t > cruise_end && t <= total_t) begin
          accel = neg_sat(signed_dir(amax));
          speed = add_sat(speed, fx_mul(accel, period));
          if (signed_dir(speed) < 0) speed = 0;
          rel_pos = add_sat(rel_pos, fx_mul(speed, period));
          if (signed_dir(rel_pos) >= bound) rel_pos = target;
        end
      end else begin
        half = total_t / 2;
        if (t > 0 && t <= half) begin
          accel = signed_dir(amax);
          speed = add_sat(speed, fx_mul(accel, period));
          rel_pos = add_sat(rel_pos, fx_mul(speed, period));
        end else if (t > half && t <= total_t) begin
          accel = neg_sat(signed_dir(amax));
          speed = add_sat(speed, fx_mul(accel, period));
          rel_pos = add_sat(rel_pos, fx_mul(speed, period));
          if (signed_dir(rel_pos) >= bound) begin
            rel_pos = target;
            speed = 0;
            accel = 0;
          end
        end
      end
      if (t > total_t) begin
        if (signed_dir(rel_pos) < bound) rel_pos = target;
        stop_motion(0);
        done = 1;
        finishes++;
      end
      r.pos = rel_pos;
      r.speed = speed;
      r.accel = accel;
      r.origin = origin;
      r.moving = moved;
      r.finished = done;
      pending_samples.push_back(r);
    endfunction

    function void compare_sample(sample_t got);
      sample_t e;
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected word pos=%0d", $time, got.pos);
        errors++;
        return;
      end
      e = pending_samples.pop_front();
      checked++;
      if (got.pos !== e.pos) begin
        $display("%0t: position exp %0d got %0d", $time, e.pos, got.pos);
        errors++;
      end
      if (got.speed !== e.speed) begin
        $display("%0t: speed exp %0d got %0d", $time, e.speed, got.speed);
        errors++;
      end
      if (got.accel !== e.accel) begin
        $display("%0t: accel exp %0d got %0d", $time, e.accel, got.accel);
        errors++;
      end
      if (got.origin !== e.origin) begin
        $display("%0t: start exp %0d got %0d", $time, e.origin, got.origin);
        errors++;
      end
      if (got.moving !== e.moving) begin
        $display("%0t: moving exp %0b got %0b", $time, e.moving, got.moving);
        errors++;
      end
      if (got.finished !== e.finished) begin
        $display("%0t: finished exp %0b got %0b", $time, e.finished, got.finished);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;
  localparam q_t ONE_RAD = 64'sd1 << 32;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [62:0] cfg_data_i;
  int          in_idle, out_idle, quiet_cycles;
  q_t          goal, pos_now;

  tmp_in_if  in_if();
  tmp_out_if out_if();
  motion_scoreboard sb;

  trapezoidal_motion_profile dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic send_tick(q_t req, q_t meas, logic ab, logic clr);
    tick_t w;
    while ($urandom_range(99) < in_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.requested_position <= req;
    in_if.measured_position <= meas;
    in_if.abort <= ab;
    in_if.abort_clear_position <= clr;
    do @(posedge clk_i); while (!in_if.ready);
    w.req = req;
    w.meas = meas;
    w.abort = ab;
    w.clear_pos = clr;
    sb.advance_profile(w);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [62:0] data);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic set_motion(logic [62:0] v, logic [62:0] a, logic [62:0] p);
    write_reg(REG_MAX_SPEED, v);
    write_reg(REG_MAX_ACCEL, a);
    write_reg(REG_PERIOD, p);
  endtask

  function automatic q_t add_meas(q_t p, int unsigned extra);
    return p + q_t'($urandom_range(1 << 18)) - (64'sd1 << 17) + q_t'(extra);
  endfunction

  // mostly coherent moves: new goal now and then, measured drifts in small random steps
  task automatic random_ticks(int n);
    int k;
    q_t off;
    logic ab, clr;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      ab = ($urandom_range(99) < 2);
      clr = 1'($urandom_range(1));
      if (i == n / 2) drain();
      if (k < 6) begin
        send_tick({$urandom, $urandom}, {$urandom, $urandom}, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end else begin
        if (k < 14) begin
          if ($urandom_range(9) == 0) off = THRESH + $urandom_range(2) - 1;
          else off = q_t'($urandom_range(32'hffff_ffff)) << $urandom_range(3);
          if ($urandom_range(1)) off = -off;
          pos_now = add_meas(pos_now, $urandom_range(1 << 20));
          goal = goal + off;
        end else begin
          pos_now = add_meas(pos_now, 0);
        end
        send_tick(goal, pos_now, ab, clr);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_idle = 0;
    out_idle = 0;
    goal = 0;
    pos_now = 0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= REG_MAX_SPEED;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.requested_position <= '0;
    in_if.measured_position <= '0;
    in_if.abort <= 1'b0;
    in_if.abort_clear_position <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // at the start threshold, then a real move
    send_tick(THRESH, 0, 0, 0);
    send_tick(ONE_RAD, 0, 0, 0);
    send_tick(ONE_RAD, 64'sd1000, 0, 0);
    send_tick(ONE_RAD, 0, 0, 1);
    send_tick(ONE_RAD, 0, 1, 0);
    // request held but measured past it: roof with no room
    send_tick(ONE_RAD, 5 * ONE_RAD, 0, 0);
    send_tick(-ONE_RAD, ONE_RAD / 2, 0, 0);
    send_tick(-ONE_RAD, ONE_RAD / 2, 1, 1);
    send_tick(SMAX, SMIN, 0, 0);
    send_tick(SMAX, SMIN, 0, 0);
    send_tick(SMIN, SMAX, 1, 0);
    send_tick(SMIN, SMAX, 0, 0);
    send_tick(-64'sd1, 64'sd0, 1, 1);
    send_tick(64'sd0, -64'sd1, 1, 1);
    set_motion(63'h7fff_ffff_ffff_ffff, 63'd1, 63'h1_0000_0000);
    send_tick(3 * ONE_RAD, 0, 0, 0);
    send_tick(3 * ONE_RAD, 0, 0, 0);
    send_tick(SMIN, SMAX, 1, 1);
    set_motion(63'd1, 63'h7fff_ffff_ffff_ffff, 63'd1);
    send_tick(ONE_RAD, 0, 1, 1);
    send_tick(ONE_RAD, 0, 0, 0);
    send_tick(SMAX, 0, 1, 1);
    send_tick(SMAX, 0, 0, 0);
    send_tick(0, 0, 1, 1);

    set_motion(63'd10 << 32, 63'd50 << 32, 63'd1 << 25);
    send_tick(0, 0, 1, 1);
    in_idle = 9;
    out_idle = 73;
    random_ticks(420);
    set_motion(63'd2 << 32, 63'd400 << 32, 63'd1 << 24);
    send_tick(goal, pos_now, 1, 1);
    in_idle = 73;
    out_idle = 9;
    random_ticks(420);
    set_motion(63'd50 << 32, 63'd5 << 32, 63'd1 << 27);
    send_tick(goal, pos_now, 1, 1);
    in_idle = 0;
    out_idle = 0;
    random_ticks(420);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("ticks %0d checked %0d: %0d profile starts, %0d finished, %0d aborts",
             sb.ticks, sb.checked, sb.starts, sb.finishes, sb.aborts);
    $display("shapes: trapezoid and roof over six register settings, mismatches %0d",
             sb.errors);
    if (sb.errors == 0 && sb.pending_samples.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= out_idle);
      if (out_if.valid && out_if.ready) begin
        got.pos = out_if.profile_position;
        got.speed = out_if.profile_speed;
        got.accel = out_if.profile_accel;
        got.origin = out_if.start_position;
        got.moving = out_if.moving;
        got.finished = out_if.finished;
        sb.compare_sample(got);
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

### filelist.f
+incdir+rtl
rtl/tmp_pkg.sv
rtl/tmp_if.sv
rtl/tmp_mul.sv
rtl/tmp_div.sv
rtl/tmp_datapath.sv
rtl/tmp_ctrl.sv
rtl/trapezoidal_motion_profile.sv
tb/trapezoidal_motion_profile_tb.sv
